// ----- rtl/core/audio_downward_expander_macros.svh -----
// Assertion macros shared by the checker of the downward expander.
`ifndef AUDIO_DOWNWARD_EXPANDER_MACROS_SVH
`define AUDIO_DOWNWARD_EXPANDER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ADX_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define ADX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/adx_pkg.sv -----
// Package: widths, register indexes, states and the log2/exp2 tables.
`timescale 1ns / 1ps
`default_nettype none
package adx_pkg;

  localparam int SAMPLE_W = 16;
  localparam int LOG_B    = 8;
  localparam int TAB_N    = 1 << LOG_B;
  localparam int ENV_W    = 24;
  localparam int GAIN_W   = 17;
  localparam int LOG_W    = 21;
  localparam int RATIO_W  = 12;
  localparam int MUL_W    = 26;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 3;

  localparam logic [GAIN_W-1:0] UNITY_GAIN = 17'd65536;
  localparam logic [GAIN_W-1:0] FLOOR_GAIN = 17'd66;
  localparam logic [RATIO_W-1:0] RATIO_MIN = 12'd256;
  localparam logic [RATIO_W-1:0] RATIO_MAX = 12'd2560;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE    = 3'd0,
    CFG_THRESHOLD = 3'd1,
    CFG_CLOSE_THR = 3'd2,
    CFG_RATIO     = 3'd3,
    CFG_ATTACK    = 3'd4,
    CFG_RELEASE   = 3'd5
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ENV_MUL,
    ST_ENV_UPD,
    ST_LOG_T,
    ST_LOG_E,
    ST_T_MUL,
    ST_GAIN,
    ST_OUT_MUL,
    ST_FINISH
  } state_t;

  typedef logic [15:0]       log_lut_t [TAB_N];
  typedef logic [GAIN_W-1:0] exp_lut_t [TAB_N];

  function automatic logic [63:0] isqrt64(logic [63:0] v0);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bit_q;
    v = v0;
    res = '0;
    bit_q = 64'd1 << 62;
    for (int k = 0; k < 32; k++) if (bit_q > v) bit_q = bit_q >> 2;
    for (int k = 0; k < 32; k++) begin
      if (bit_q != 0) begin
        if (v >= res + bit_q) begin
          v = v - (res + bit_q);
          res = (res >> 1) + bit_q;
        end else begin
          res = res >> 1;
        end
        bit_q = bit_q >> 2;
      end
    end
    return res;
  endfunction

  // Fraction of log2(1 + i/2^B), 16 bits, by repeated squaring in Q1.30.
  function automatic log_lut_t build_log();
    log_lut_t tab;
    logic [63:0] m;
    logic [15:0] frac;
    for (int i = 0; i < TAB_N; i++) begin
      m = (64'd1 << 30) + (64'(i) << (30 - LOG_B));
      frac = '0;
      for (int k = 0; k < 16; k++) begin
        m = (m * m) >> 30;
        frac = frac << 1;
        if (m >= (64'd2 << 30)) begin
          frac = frac | 16'd1;
          m = m >> 1;
        end
      end
      tab[i] = frac;
    end
    return tab;
  endfunction

  // 2^(-j/2^B) in Q1.16, from a product of repeated square roots of 0.5.
  function automatic exp_lut_t build_exp();
    exp_lut_t tab;
    logic [63:0] roots [LOG_B+1];
    logic [63:0] p;
    roots[0] = 64'd1 << 30;
    roots[1] = isqrt64(64'd1 << 59);
    for (int k = 2; k <= LOG_B; k++) roots[k] = isqrt64(roots[k-1] << 30);
    for (int i = 0; i < TAB_N; i++) begin
      p = 64'd1 << 30;
      for (int k = 1; k <= LOG_B; k++) begin
        if (((i >> (LOG_B - k)) & 1) != 0) p = (p * roots[k]) >> 30;
      end
      p = (p + (64'd1 << 13)) >> 14;
      tab[i] = p[GAIN_W-1:0];
    end
    return tab;
  endfunction

  localparam log_lut_t LOG_LUT = build_log();
  localparam exp_lut_t EXP_LUT = build_exp();

endpackage
`default_nettype wire

// ----- rtl/core/adx_if.sv -----
// Valid/ready channel interfaces for samples in and results out.
`timescale 1ns / 1ps
`default_nettype none
interface adx_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [adx_pkg::SAMPLE_W-1:0] sample_in;
  logic                              block_end;
  modport source (output valid, output sample_in, output block_end, input ready);
  modport sink   (input valid, input sample_in, input block_end, output ready);
endinterface

interface adx_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [adx_pkg::SAMPLE_W-1:0] sample_out;
  logic [adx_pkg::GAIN_W-1:0]          gain;
  logic                              gate_open;
  logic                              block_end_out;
  modport source (output valid, output sample_out, output gain, output gate_open,
                  output block_end_out, input ready);
  modport sink   (input valid, input sample_out, input gain, input gate_open,
                  input block_end_out, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/audio_downward_expander.sv -----
// Top level: downward expander with envelope follower and sequencer.
//
//   channel  | direction | handshake   | payload
//   in_ch    | in        | valid/ready | sample_in, block_end
//   out_ch   | out       | valid/ready | sample_out, gain, gate_open, block_end_out
//   cfg_*    | in        | write only  | cfg_idx selects register, cfg_data value
//
// An enabled sample runs ENV_MUL, ENV_UPD, LOG_T, LOG_E, T_MUL, GAIN, OUT_MUL, then
// FINISH loads the result register; the exponent multiply and lookup (T_MUL, GAIN) are
// skipped when the envelope is zero or at/above threshold, and a disabled sample goes
// straight to OUT_MUL. Ready returns only when the result register loads. One shared
// 26x26 multiplier serves the envelope update, ratio scaling and gain multiply in turn.
// Reset is synchronous, active low; it restores register defaults, zeroes the envelope
// and closes the gate. A result waiting at out_ch does not stop the next transfer in;
// the sequencer only holds in its last step while the result register is still full.
`timescale 1ns / 1ps
`default_nettype none
module audio_downward_expander (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  adx_in_if.sink                                   in_ch,
  adx_out_if.source                                out_ch,
  input  wire logic                                cfg_we,
  input  wire logic [adx_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  wire logic [adx_pkg::CFG_W-1:0]           cfg_data
);
  import adx_pkg::*;

  // Configuration registers.
  logic               enable_r;
  logic [ENV_W-1:0]   thr_r;
  logic [ENV_W-1:0]   close_thr_r;
  logic [RATIO_W-1:0] ratio_r;
  logic [ENV_W-1:0]   attack_r;
  logic [ENV_W-1:0]   release_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b1;
      thr_r       <= 24'd83886;
      close_thr_r <= 24'd59388;
      ratio_r     <= 12'd512;
      attack_r    <= 24'd16707457;
      release_r   <= 24'd16773721;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_ENABLE:    enable_r    <= cfg_data[0];
        CFG_THRESHOLD: thr_r       <= cfg_data[ENV_W-1:0];
        CFG_CLOSE_THR: close_thr_r <= cfg_data[ENV_W-1:0];
        CFG_RATIO:     ratio_r     <= cfg_data[RATIO_W-1:0];
        CFG_ATTACK:    attack_r    <= cfg_data[ENV_W-1:0];
        CFG_RELEASE:   release_r   <= cfg_data[ENV_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and datapath registers.
  state_t                     state_r, state_nxt;
  logic signed [SAMPLE_W-1:0] samp_r, samp_nxt;
  logic                       bend_r, bend_nxt;
  logic [ENV_W-1:0]           env_r, env_nxt;
  logic                       gate_r, gate_nxt;
  logic [LOG_W-1:0]           logt_r, logt_nxt;
  logic [LOG_W-1:0]           d_r, d_nxt;
  logic [GAIN_W-1:0]          gain_r, gain_nxt;

  logic                       ov_r, ov_nxt;
  logic signed [SAMPLE_W-1:0] osamp_r, osamp_nxt;
  logic [GAIN_W-1:0]          ogain_r, ogain_nxt;
  logic                       ogate_r, ogate_nxt;
  logic                       obend_r, obend_nxt;

  logic signed [MUL_W-1:0]    op_a, op_b;
  logic signed [PROD_W-1:0]   prod_r;
  logic [ENV_W-1:0]           log_x;
  logic [LOG_W-1:0]           log_q;

  adx_mul u_mul (.clk(clk), .op_a(op_a), .op_b(op_b), .prod_r(prod_r));
  adx_log u_log (.x(log_x), .log_q(log_q));

  // Envelope step terms.
  logic [SAMPLE_W:0]          mag;
  logic [ENV_W-1:0]           level;
  logic [ENV_W-1:0]           coef;
  logic [ENV_W:0]             one_minus_c;
  logic signed [ENV_W+1:0]    diff;
  logic signed [PROD_W-1:0]   env_round;
  logic signed [MUL_W-1:0]    env_inc;
  logic [MUL_W-1:0]           env_sum;
  // Gain terms.
  logic [RATIO_W-1:0]         ratio_sat;
  logic [RATIO_W-1:0]         ratio_m1;
  logic [PROD_W-1:0]          t_round;
  logic [8:0]                 t_int;
  logic [LOG_B-1:0]           t_idx;
  logic [GAIN_W-1:0]          g_tab;
  logic [GAIN_W:0]            g_shift;
  logic [ENV_W-1:0]           eff_thr;
  logic signed [PROD_W-1:0]   out_round;
  logic                       out_free;
  logic                       in_xfer;

  always_comb begin
    mag = samp_r[SAMPLE_W-1] ? (SAMPLE_W+1)'(-(SAMPLE_W+1)'(samp_r))
                             : (SAMPLE_W+1)'(samp_r);
    level = ENV_W'(mag) << 8;
    coef = (level > env_r) ? attack_r : release_r;
    one_minus_c = (ENV_W+1)'(1) << ENV_W;
    one_minus_c = one_minus_c - (ENV_W+1)'(coef);
    diff = $signed({2'b00, level}) - $signed({2'b00, env_r});
    env_round = prod_r + (PROD_W)'(1 << 23);
    env_inc = env_round[MUL_W+23:24];
    env_sum = MUL_W'(env_r) + env_inc;

    ratio_sat = (ratio_r < RATIO_MIN) ? RATIO_MIN :
                (ratio_r > RATIO_MAX) ? RATIO_MAX : ratio_r;
    ratio_m1 = ratio_sat - RATIO_MIN;

    t_round = prod_r + PROD_W'(128);
    t_int = t_round[32:24];
    t_idx = t_round[23 -: LOG_B];
    g_tab = EXP_LUT[t_idx];
    g_shift = ({1'b0, g_tab} + ((GAIN_W+1)'(1) << (t_int[4:0] - 5'd1))) >> t_int[4:0];

    eff_thr = gate_r ? close_thr_r : thr_r;
    out_round = prod_r + PROD_W'(32768);
  end

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer = in_ch.valid && in_ch.ready;
  assign out_free = !ov_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      env_r   <= '0;
      gate_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      env_r   <= env_nxt;
      gate_r  <= gate_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    samp_r  <= samp_nxt;
    bend_r  <= bend_nxt;
    logt_r  <= logt_nxt;
    d_r     <= d_nxt;
    gain_r  <= gain_nxt;
    osamp_r <= osamp_nxt;
    ogain_r <= ogain_nxt;
    ogate_r <= ogate_nxt;
    obend_r <= obend_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    samp_nxt  = samp_r;
    bend_nxt  = bend_r;
    env_nxt   = env_r;
    gate_nxt  = gate_r;
    logt_nxt  = logt_r;
    d_nxt     = d_r;
    gain_nxt  = gain_r;
    ov_nxt    = ov_r && !out_ch.ready;
    osamp_nxt = osamp_r;
    ogain_nxt = ogain_r;
    ogate_nxt = ogate_r;
    obend_nxt = obend_r;
    // Default operands keep sample times gain on the product register.
    op_a  = MUL_W'(samp_r);
    op_b  = $signed({(MUL_W-GAIN_W)'(0), gain_r});
    log_x = thr_r;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          samp_nxt = in_ch.sample_in;
          bend_nxt = in_ch.block_end;
          if (enable_r) begin
            state_nxt = ST_ENV_MUL;
          end else begin
            gain_nxt  = UNITY_GAIN;
            state_nxt = ST_OUT_MUL;
          end
        end
      end
      ST_ENV_MUL: begin
        op_a = MUL_W'(diff);
        op_b = $signed({1'b0, one_minus_c});
        state_nxt = ST_ENV_UPD;
      end
      ST_ENV_UPD: begin
        env_nxt   = env_sum[ENV_W-1:0];
        state_nxt = ST_LOG_T;
      end
      ST_LOG_T: begin
        log_x = thr_r;
        logt_nxt = log_q;
        if (env_r > thr_r) gate_nxt = 1'b1;
        else if (env_r < eff_thr) gate_nxt = 1'b0;
        state_nxt = ST_LOG_E;
      end
      ST_LOG_E: begin
        log_x = env_r;
        d_nxt = logt_r - log_q;
        if (env_r == '0) begin
          gain_nxt  = FLOOR_GAIN;
          state_nxt = ST_OUT_MUL;
        end else if (env_r >= thr_r) begin
          gain_nxt  = UNITY_GAIN;
          state_nxt = ST_OUT_MUL;
        end else begin
          state_nxt = ST_T_MUL;
        end
      end
      ST_T_MUL: begin
        op_a = $signed({(MUL_W-LOG_W)'(0), d_r});
        op_b = $signed({(MUL_W-RATIO_W)'(0), ratio_m1});
        state_nxt = ST_GAIN;
      end
      ST_GAIN: begin
        // Integer part of the exponent is a right shift; drop to zero past 16.
        if (t_int >= 9'd17) gain_nxt = '0;
        else if (t_int == 9'd0) gain_nxt = g_tab;
        else gain_nxt = g_shift[GAIN_W-1:0];
        state_nxt = ST_OUT_MUL;
      end
      ST_OUT_MUL: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          osamp_nxt = out_round[SAMPLE_W+15:16];
          ogain_nxt = gain_r;
          ogate_nxt = gate_r;
          obend_nxt = bend_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.sample_out    = osamp_r;
  assign out_ch.gain          = ogain_r;
  assign out_ch.gate_open     = ogate_r;
  assign out_ch.block_end_out = obend_r;
endmodule
`default_nettype wire

// ----- rtl/core/adx_mul.sv -----
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps
`default_nettype none
module adx_mul (
  input  wire logic                              clk,
  input  wire logic signed [adx_pkg::MUL_W-1:0]  op_a,
  input  wire logic signed [adx_pkg::MUL_W-1:0]  op_b,
  output logic signed [adx_pkg::PROD_W-1:0]      prod_r
);
  import adx_pkg::*;

  logic signed [PROD_W-1:0] prod_nxt;

  assign prod_nxt = PROD_W'(op_a) * PROD_W'(op_b);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end
endmodule
`default_nettype wire

// ----- rtl/core/adx_log.sv -----
// log2 in Q5.16: leading-one position plus table fraction.
`timescale 1ns / 1ps
`default_nettype none
module adx_log (
  input  wire logic [adx_pkg::ENV_W-1:0] x,
  output logic [adx_pkg::LOG_W-1:0]      log_q
);
  import adx_pkg::*;

  logic [4:0]       msb;
  logic [ENV_W-1:0] norm;
  logic [LOG_B-1:0] idx;

  always_comb begin
    msb = '0;
    for (int i = 1; i < ENV_W; i++) begin
      if (x[i]) msb = 5'(i);
    end
    norm = x << (5'(ENV_W - 1) - msb);
    idx = norm[ENV_W-2 -: LOG_B];
    log_q = {msb, 16'd0} + LOG_W'(LOG_LUT[idx]);
  end
endmodule
`default_nettype wire

// ----- rtl/core/adx_checker.sv -----
// Port-level checker for the downward expander, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "audio_downward_expander_macros.svh"
module adx_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic signed [adx_pkg::SAMPLE_W-1:0] sample_out,
  input wire logic [adx_pkg::GAIN_W-1:0]          gain
);
  import adx_pkg::*;

  `ADX_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "ready after transfer")
  `ADX_ASSERT_NOW(a_gain_range, out_valid, gain <= UNITY_GAIN, "gain above unity")
  `ADX_ASSERT_NOW(a_zero_gain, out_valid && gain == '0, sample_out == '0, "muted sample nonzero")
  `ADX_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(gain), "result dropped")
endmodule

bind audio_downward_expander adx_checker u_adx_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .sample_out(out_ch.sample_out), .gain(out_ch.gain)
);
`default_nettype wire
